// ===== rtl/ptc_pkg.sv =====
package ptc_pkg;

	localparam int D_W   = 24;
	localparam int CAL_W = 16;
	localparam int IDX_W = 3;
	localparam int OUT_W = 32;
	localparam int N_STG = 9;

	localparam int TEMP_REF  = 2000;
	localparam int TEMP_VLOW = -1500;

	typedef enum logic [IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} cal_t;

	typedef logic signed [24:0] dt_t;
	typedef logic signed [40:0] prod_t;
	typedef logic signed [49:0] dsq_t;
	typedef logic        [47:0] dtsq_t;
	typedef logic signed [18:0] temp_t;
	typedef logic signed [19:0] tf_t;
	typedef logic        [16:0] ti_t;
	typedef logic signed [35:0] off_t;
	typedef logic signed [34:0] sens_t;
	typedef logic signed [37:0] devsq_t;
	typedef logic        [34:0] sq_t;
	typedef logic        [37:0] offc_t;
	typedef logic        [36:0] sensc_t;
	typedef logic signed [39:0] fin_t;
	typedef logic signed [43:0] pp_t;
	typedef logic        [43:0] ppu_t;
	typedef logic signed [63:0] acc_t;
	typedef logic signed [42:0] a_t;
	typedef logic signed [43:0] dif_t;
	typedef logic signed [OUT_W-1:0] out_t;

endpackage

// ===== rtl/ptc_cal_regs.sv =====
module ptc_cal_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [ptc_pkg::IDX_W-1:0] wr_index,
	input  logic [ptc_pkg::CAL_W-1:0] wr_data,
	output ptc_pkg::cal_t             cal
);

	ptc_pkg::cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				ptc_pkg::REG_C1: cal_q.c1 <= wr_data;
				ptc_pkg::REG_C2: cal_q.c2 <= wr_data;
				ptc_pkg::REG_C3: cal_q.c3 <= wr_data;
				ptc_pkg::REG_C4: cal_q.c4 <= wr_data;
				ptc_pkg::REG_C5: cal_q.c5 <= wr_data;
				ptc_pkg::REG_C6: cal_q.c6 <= wr_data;
				default: ;
			endcase
		end
	end

	assign cal = cal_q;

endmodule

// ===== rtl/pressure_temp_compensation.sv =====
// Second-order pressure/temperature compensation for a 24-bit sensor with six
// 16-bit calibration words (register indexes 0..5 = C1..C6; other indexes are
// ignored). Fully pipelined: one sample pair is accepted per cycle unless
// stalled; the nine register stages each hold at most one multiplier or two
// chained adds per path. Stages with no item absorb stalls, so input is
// refused only when every stage is full and the output is stalled.
// Calibration words must be written only while the pipeline is empty.
module pressure_temp_compensation (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ptc_pkg::D_W-1:0]          raw_pressure,
	input  logic [ptc_pkg::D_W-1:0]          raw_temperature,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [ptc_pkg::OUT_W-1:0] pressure,
	output logic signed [ptc_pkg::OUT_W-1:0] temperature_first,
	output logic signed [ptc_pkg::OUT_W-1:0] temperature_final,
	input  logic                             wr_en,
	input  logic [ptc_pkg::IDX_W-1:0]        wr_index,
	input  logic [ptc_pkg::CAL_W-1:0]        wr_data
);

	ptc_pkg::cal_t cal;

	ptc_cal_regs u_cal (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cal      (cal)
	);

	// valid / ready chain
	logic [ptc_pkg::N_STG:1] vld_q;
	logic [ptc_pkg::N_STG:1] rdy;
	logic [ptc_pkg::N_STG:1] vin;

	always_comb begin
		rdy[ptc_pkg::N_STG] = !vld_q[ptc_pkg::N_STG] || !out_stall;
		for (int k = ptc_pkg::N_STG - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		vin[1] = in_valid;
		for (int k = 2; k <= ptc_pkg::N_STG; k++) begin
			vin[k] = vld_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= ptc_pkg::N_STG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	logic [ptc_pkg::N_STG:1] ld;
	assign ld = rdy & vin;

	// stage 1: dT
	ptc_pkg::dt_t           dt_s1;
	logic [ptc_pkg::D_W-1:0] d1_s1;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});
			d1_s1 <= raw_pressure;
		end
	end

	// stage 2: products of dT
	ptc_pkg::prod_t          pt_s2, po_s2, ps_s2;
	ptc_pkg::dtsq_t          pdd_s2;
	logic [ptc_pkg::D_W-1:0] d1_s2;
	ptc_pkg::dsq_t           dsq;

	assign dsq = ptc_pkg::dsq_t'(dt_s1) * ptc_pkg::dsq_t'(dt_s1);

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			pt_s2  <= ptc_pkg::prod_t'(dt_s1) * ptc_pkg::prod_t'($signed({1'b0, cal.c6}));
			po_s2  <= ptc_pkg::prod_t'(dt_s1) * ptc_pkg::prod_t'($signed({1'b0, cal.c4}));
			ps_s2  <= ptc_pkg::prod_t'(dt_s1) * ptc_pkg::prod_t'($signed({1'b0, cal.c3}));
			pdd_s2 <= dsq[47:0];
			d1_s2  <= d1_s1;
		end
	end

	// stage 3: first order, branch flags, Ti
	ptc_pkg::temp_t dev_c, t1_c, lo_c;
	ptc_pkg::off_t  off_c;
	ptc_pkg::sens_t sens_c;
	logic [49:0]    dd3_c;
	ptc_pkg::ti_t   ti_c;

	always_comb begin
		dev_c  = ptc_pkg::temp_t'($signed(pt_s2[40:23]));
		t1_c   = dev_c + ptc_pkg::temp_t'(ptc_pkg::TEMP_REF);
		lo_c   = dev_c + ptc_pkg::temp_t'(ptc_pkg::TEMP_REF - ptc_pkg::TEMP_VLOW);
		off_c  = $signed({4'b0000, cal.c2, 16'h0000})
			+ ptc_pkg::off_t'($signed(po_s2[40:7]));
		sens_c = $signed({4'b0000, cal.c1, 15'h0000})
			+ ptc_pkg::sens_t'($signed(ps_s2[40:8]));
		dd3_c  = {2'b00, pdd_s2} + {1'b0, pdd_s2, 1'b0};
		ti_c   = pt_s2[40] ? dd3_c[49:33] : {5'b00000, pdd_s2[47:36]};
	end

	ptc_pkg::temp_t          dev_s3, t1_s3, lo_s3;
	ptc_pkg::off_t           off_s3;
	ptc_pkg::sens_t          sens_s3;
	ptc_pkg::ti_t            ti_s3;
	logic                    low_s3, vlow_s3;
	logic [ptc_pkg::D_W-1:0] d1_s3;

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			dev_s3  <= dev_c;
			t1_s3   <= t1_c;
			lo_s3   <= lo_c;
			off_s3  <= off_c;
			sens_s3 <= sens_c;
			ti_s3   <= ti_c;
			low_s3  <= pt_s2[40];
			vlow_s3 <= lo_c[18];
			d1_s3   <= d1_s2;
		end
	end

	// stage 4: squares, final temperature
	ptc_pkg::devsq_t dv2, lv2;

	assign dv2 = ptc_pkg::devsq_t'(dev_s3) * ptc_pkg::devsq_t'(dev_s3);
	assign lv2 = ptc_pkg::devsq_t'(lo_s3) * ptc_pkg::devsq_t'(lo_s3);

	ptc_pkg::sq_t            dev2_s4, lo2_s4;
	ptc_pkg::temp_t          t1_s4;
	ptc_pkg::tf_t            tf_s4;
	ptc_pkg::off_t           off_s4;
	ptc_pkg::sens_t          sens_s4;
	logic                    low_s4, vlow_s4;
	logic [ptc_pkg::D_W-1:0] d1_s4;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			dev2_s4 <= dv2[34:0];
			lo2_s4  <= lv2[34:0];
			t1_s4   <= t1_s3;
			tf_s4   <= ptc_pkg::tf_t'(t1_s3) - ptc_pkg::tf_t'(ti_s3);
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
			low_s4  <= low_s3;
			vlow_s4 <= vlow_s3;
			d1_s4   <= d1_s3;
		end
	end

	// stage 5: second-order corrections
	logic [37:0]     d3_c, l7_c;
	logic [36:0]     d5_c, l4_c;
	ptc_pkg::offc_t  offi_c;
	ptc_pkg::sensc_t sensi_c;

	always_comb begin
		d3_c = {3'b000, dev2_s4} + {2'b00, dev2_s4, 1'b0};
		l7_c = {lo2_s4, 3'b000} - {3'b000, lo2_s4};
		d5_c = {dev2_s4, 2'b00} + {2'b00, dev2_s4};
		l4_c = {lo2_s4, 2'b00};
		if (low_s4) begin
			offi_c  = {1'b0, d3_c[37:1]} + (vlow_s4 ? l7_c : '0);
			sensi_c = {3'b000, d5_c[36:3]} + (vlow_s4 ? l4_c : '0);
		end else begin
			offi_c  = {7'b0000000, dev2_s4[34:4]};
			sensi_c = '0;
		end
	end

	ptc_pkg::offc_t          offi_s5;
	ptc_pkg::sensc_t         sensi_s5;
	ptc_pkg::off_t           off_s5;
	ptc_pkg::sens_t          sens_s5;
	ptc_pkg::temp_t          t1_s5;
	ptc_pkg::tf_t            tf_s5;
	logic [ptc_pkg::D_W-1:0] d1_s5;

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			offi_s5  <= offi_c;
			sensi_s5 <= sensi_c;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			t1_s5    <= t1_s4;
			tf_s5    <= tf_s4;
			d1_s5    <= d1_s4;
		end
	end

	// stage 6: corrected offset and sensitivity
	ptc_pkg::fin_t           offf_s6, sensf_s6;
	ptc_pkg::temp_t          t1_s6;
	ptc_pkg::tf_t            tf_s6;
	logic [ptc_pkg::D_W-1:0] d1_s6;

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			offf_s6  <= ptc_pkg::fin_t'(off_s5) - ptc_pkg::fin_t'(offi_s5);
			sensf_s6 <= ptc_pkg::fin_t'(sens_s5) - ptc_pkg::fin_t'(sensi_s5);
			t1_s6    <= t1_s5;
			tf_s6    <= tf_s5;
			d1_s6    <= d1_s5;
		end
	end

	// stage 7: D1 * SENS as two partial products
	ptc_pkg::pp_t   ph_s7;
	ptc_pkg::ppu_t  pl_s7;
	ptc_pkg::fin_t  offf_s7;
	ptc_pkg::temp_t t1_s7;
	ptc_pkg::tf_t   tf_s7;

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			ph_s7   <= ptc_pkg::pp_t'($signed({1'b0, d1_s6}))
				* ptc_pkg::pp_t'($signed(sensf_s6[39:20]));
			pl_s7   <= ptc_pkg::ppu_t'(d1_s6) * ptc_pkg::ppu_t'(sensf_s6[19:0]);
			offf_s7 <= offf_s6;
			t1_s7   <= t1_s6;
			tf_s7   <= tf_s6;
		end
	end

	// stage 8: combine partial products, >> 21
	ptc_pkg::acc_t  full_c;
	ptc_pkg::a_t    a_s8;
	ptc_pkg::fin_t  offf_s8;
	ptc_pkg::temp_t t1_s8;
	ptc_pkg::tf_t   tf_s8;

	assign full_c = $signed({ph_s7, 20'h00000}) + $signed({20'h00000, pl_s7});

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			a_s8    <= full_c[63:21];
			offf_s8 <= offf_s7;
			t1_s8   <= t1_s7;
			tf_s8   <= tf_s7;
		end
	end

	// stage 9: subtract offset, >> 13; output register
	// all results fit in 32 bits, so saturation reduces to sign extension
	ptc_pkg::dif_t diff_c;
	ptc_pkg::out_t press_s9, tfirst_s9, tfinal_s9;

	assign diff_c = ptc_pkg::dif_t'(a_s8) - ptc_pkg::dif_t'(offf_s8);

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			press_s9  <= ptc_pkg::out_t'($signed(diff_c[43:13]));
			tfirst_s9 <= ptc_pkg::out_t'(t1_s8);
			tfinal_s9 <= ptc_pkg::out_t'(tf_s8);
		end
	end

	assign in_stall          = !rdy[1];
	assign out_valid         = vld_q[ptc_pkg::N_STG];
	assign pressure          = press_s9;
	assign temperature_first = tfirst_s9;
	assign temperature_final = tfinal_s9;

	// input refused only when the whole pipe is full and the output stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && (&vld_q)))
		else $error("input stalled with room in pipeline");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[ptc_pkg::N_STG-1] && rdy[ptc_pkg::N_STG]) |=> out_valid)
		else $error("item lost in last stage");

	a_tcorr_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (temperature_final <= temperature_first))
		else $error("second-order temperature above first-order");

	a_tcorr_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && temperature_first >= ptc_pkg::TEMP_REF)
		|-> (temperature_first - temperature_final <= 32'sd4095))
		else $error("high-temperature correction out of range");

endmodule
